### hw/rtl/lmts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmts_pkg
// Types, mode codes, timing constants and small-quotient modulo helper for
// the LCD mode timing sequencer.
// ----------------------------------------------------------------------------
package lmts_pkg;

	localparam int CYC_W  = 8;
	localparam int MC_W   = 11;
	localparam int VLC_W  = 9;
	localparam int LINE_W = 8;
	// worst quotient: OAM search entered with up to 254 carried cycles out of
	// vblank, plus 255 new ones, over the OAM search length OAM_LEN
	localparam int Q_MAX  = 25;

	localparam logic [MC_W-1:0]   OAM_LEN        = MC_W'(20);
	localparam logic [MC_W-1:0]   XFER_LEN       = MC_W'(43);
	localparam logic [MC_W-1:0]   HBLANK_LEN     = MC_W'(51);
	localparam logic [MC_W-1:0]   VBL_LEN        = MC_W'(1140);
	localparam logic [MC_W-1:0]   VBL_LINE_LEN   = MC_W'(114);
	localparam logic [LINE_W-1:0] VBL_START_LINE = LINE_W'(144);

	typedef enum logic [1:0] {
		MODE_HBLANK = 2'd0,
		MODE_VBLANK = 2'd1,
		MODE_OAM    = 2'd2,
		MODE_XFER   = 2'd3
	} lmts_mode_t;

	typedef struct packed {
		lmts_mode_t        mode;
		logic [MC_W-1:0]   mode_cycles;
		logic [VLC_W-1:0]  vbl_cycles;
		logic [LINE_W-1:0] line;
	} lmts_state_t;

	typedef struct packed {
		lmts_mode_t        mode;
		logic [LINE_W-1:0] line;
		logic              vblank_irq;
		logic              frame_done;
		logic              sprite_search_event;
		logic              line_render_event;
	} lmts_result_t;

	// Remainder for a short quotient: parallel threshold compares against
	// multiples of a constant divisor, highest matching multiple wins.
	function automatic logic [MC_W-1:0] mod_small(input logic [MC_W-1:0] x,
			input logic [MC_W-1:0] c);
		logic [MC_W-1:0] r;
		logic [MC_W+3:0] t;
		r = x;
		for (int k = 1; k <= Q_MAX; k++) begin
			t = (MC_W+4)'(k) * {4'b0, c};
			if ({4'b0, x} >= t) begin
				r = x - t[MC_W-1:0];
			end
		end
		return r;
	endfunction

endpackage
`default_nettype wire

### hw/rtl/lcd_mode_timing_sequencer_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcd_mode_timing_sequencer_unit
// LCD mode timing sequencer: tracks display mode and scan line from elapsed
// machine cycles and flags mode-change events.
//
//   channel  dir  handshake          payload
//   s_*      in   s_tvalid/s_tready  cpu_cycles
//   m_*      out  m_tvalid/m_tready  mode, line, flags; frame_done on m_tlast
//   cfg_*    in   cfg_valid/cfg_ready lcd_enable
//
// One item per cycle sustained while m_tready stays high. Items pass through the
// input register, then the mode/line update lands in the state and the output register together.
// Reset clears the timing state to OAM search, line 0, LCD off.
// When m_tready is low the output register holds; one more item waits in the
// input register, then s_tready drops.
// ----------------------------------------------------------------------------
module lcd_mode_timing_sequencer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // [7:0] cpu_cycles
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,    // [1:0] mode, [9:2] line, [10] vblank_irq,
	                                // [11] sprite_search_event,
	                                // [12] line_render_event, [15:13] zero
	output logic        m_tlast,    // frame_done
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data    // lcd_enable
);
	import lmts_pkg::*;

	logic              lcd_enable_q;
	lmts_state_t       state_q;
	lmts_state_t       state_nxt;
	lmts_result_t      result;
	logic              vld_s1;
	logic [CYC_W-1:0]  cyc_s1;
	logic              vld_s2;
	lmts_result_t      res_s2;
	logic              out_free;
	logic              advance;

	assign out_free = !vld_s2 || m_tready;
	assign advance  = vld_s1 && out_free;
	assign s_tready = !vld_s1 || out_free;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lcd_enable_q <= 1'b0;
		end else if (cfg_valid) begin
			lcd_enable_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cyc_s1 <= s_tdata;
		end
	end

	lmts_step u_step (
		.state_cur  (state_q),
		.cycles     (cyc_s1),
		.lcd_enable (lcd_enable_q),
		.state_nxt  (state_nxt),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode        <= MODE_OAM;
			state_q.mode_cycles <= '0;
			state_q.vbl_cycles  <= '0;
			state_q.line        <= '0;
			vld_s2              <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_nxt;
				vld_s2  <= 1'b1;
			end else if (m_tready) begin
				vld_s2  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= result;
		end
	end

	assign m_tvalid = vld_s2;
	assign m_tlast  = res_s2.frame_done;
	assign m_tdata  = {3'b000, res_s2.line_render_event, res_s2.sprite_search_event,
		res_s2.vblank_irq, res_s2.line, res_s2.mode};

endmodule
`default_nettype wire

### hw/rtl/lmts_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmts_step
// Next-state and result logic for one item: while lcd_enable is high, adds the
// elapsed cycles and moves through OAM search, transfer, hblank and vblank.
// ----------------------------------------------------------------------------
module lmts_step (
	input  lmts_pkg::lmts_state_t        state_cur,
	input  logic [lmts_pkg::CYC_W-1:0]   cycles,
	input  logic                         lcd_enable,
	output lmts_pkg::lmts_state_t        state_nxt,
	output lmts_pkg::lmts_result_t       result
);
	import lmts_pkg::*;

	logic [MC_W:0]     mc_sum_w;
	logic [MC_W-1:0]   mc_sum;
	logic [VLC_W:0]    vlc_sum_w;
	logic [VLC_W-1:0]  vlc_sum;
	logic [MC_W-1:0]   mc_len;
	logic [MC_W-1:0]   mc_rem;
	logic [MC_W-1:0]   vlc_rem;
	logic [LINE_W-1:0] line_inc;
	logic              mc_done;
	logic              irq;
	logic              done;
	logic              ssev;
	logic              lrev;

	assign mc_sum_w  = {1'b0, state_cur.mode_cycles} + {{(MC_W+1-CYC_W){1'b0}}, cycles};
	assign mc_sum    = mc_sum_w[MC_W-1:0];
	assign vlc_sum_w = {1'b0, state_cur.vbl_cycles} + {{(VLC_W+1-CYC_W){1'b0}}, cycles};
	assign vlc_sum   = vlc_sum_w[VLC_W-1:0];
	assign line_inc  = state_cur.line + LINE_W'(1);

	always_comb begin
		case (state_cur.mode)
			MODE_HBLANK: mc_len = HBLANK_LEN;
			MODE_VBLANK: mc_len = VBL_LEN;
			MODE_OAM:    mc_len = OAM_LEN;
			default:     mc_len = XFER_LEN;
		endcase
	end

	assign mc_done = (mc_sum >= mc_len);

	// one remainder per divisor, picked by the mode
	always_comb begin
		case (state_cur.mode)
			MODE_HBLANK: mc_rem = mod_small(mc_sum, HBLANK_LEN);
			MODE_VBLANK: mc_rem = mod_small(mc_sum, VBL_LEN);
			MODE_OAM:    mc_rem = mod_small(mc_sum, OAM_LEN);
			default:     mc_rem = mod_small(mc_sum, XFER_LEN);
		endcase
	end

	assign vlc_rem = mod_small({{(MC_W-VLC_W){1'b0}}, vlc_sum}, VBL_LINE_LEN);

	always_comb begin
		state_nxt = state_cur;
		irq  = 1'b0;
		done = 1'b0;
		ssev = 1'b0;
		lrev = 1'b0;
		if (lcd_enable) begin
			state_nxt.mode_cycles = mc_done ? mc_rem : mc_sum;
			case (state_cur.mode)
				MODE_HBLANK: begin
					if (mc_done) begin
						state_nxt.line = line_inc;
						if (line_inc >= VBL_START_LINE) begin
							state_nxt.mode       = MODE_VBLANK;
							state_nxt.vbl_cycles = mc_rem[VLC_W-1:0];
							irq = 1'b1;
						end else begin
							state_nxt.mode = MODE_OAM;
						end
					end
				end
				MODE_VBLANK: begin
					if (vlc_sum >= VBL_LINE_LEN[VLC_W-1:0]) begin
						state_nxt.line       = line_inc;
						state_nxt.vbl_cycles = vlc_rem[VLC_W-1:0];
					end else begin
						state_nxt.vbl_cycles = vlc_sum;
					end
					if (mc_done) begin
						state_nxt.line = '0;
						state_nxt.mode = MODE_OAM;
						done = 1'b1;
					end
				end
				MODE_OAM: begin
					if (mc_done) begin
						state_nxt.mode = MODE_XFER;
						ssev = 1'b1;
					end
				end
				default: begin
					if (mc_done) begin
						state_nxt.mode = MODE_HBLANK;
						lrev = 1'b1;
					end
				end
			endcase
		end
	end

	assign result.mode                = state_nxt.mode;
	assign result.line                = state_nxt.line;
	assign result.vblank_irq          = irq;
	assign result.frame_done          = done;
	assign result.sprite_search_event = ssev;
	assign result.line_render_event   = lrev;

endmodule
`default_nettype wire

### test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stream testbench for the LCD mode timing sequencer. Elapsed-cycle items are
// fed through the slave port, with random gaps except in the calm phase. Each
// accepted item advances a local model of mode, line and event flags. Every
// result on the master port is checked field by field against the oldest
// prediction. lcd_enable is rewritten between phases once the pipe has drained.
// ----------------------------------------------------------------------------
module tb;
	import lmts_pkg::*;

	localparam int CYCLE_LIMIT   = 300000;
	localparam int SETTLE_CYCLES = 4;

	typedef struct packed {
		logic       is_lcd;   // config write instead of a cycle item
		logic       calm;     // no idling on either side
		logic [7:0] value;
	} stim_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [15:0] m_tdata;
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_data  = 1'b0;

	stim_t        stim_q[$];
	lmts_result_t timing_q[$];
	stim_t        head;
	lmts_result_t want;

	// local copy of the timing state
	lmts_mode_t        cur_mode;
	logic [MC_W-1:0]   mode_cyc;
	logic [VLC_W-1:0]  vbl_cyc;
	logic [LINE_W-1:0] cur_line;
	logic              lcd_on;

	int unsigned send_gap;
	int unsigned sink_gap;
	int unsigned drain_cnt;
	int unsigned err_count = 0;
	int unsigned cycle_count = 0;
	logic        calm_phase = 1'b0;

	lcd_mode_timing_sequencer_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	function automatic lmts_result_t advance_timing(input logic [7:0] cyc);
		lmts_result_t r;
		r = '0;
		if (lcd_on) begin
			mode_cyc = mode_cyc + MC_W'(cyc);
			case (cur_mode)
				MODE_HBLANK: begin
					if (mode_cyc >= HBLANK_LEN) begin
						cur_line = cur_line + 1'b1;
						if (cur_line >= VBL_START_LINE) begin
							cur_mode = MODE_VBLANK;
							vbl_cyc = VLC_W'(mode_cyc % HBLANK_LEN);
							r.vblank_irq = 1'b1;
						end else begin
							cur_mode = MODE_OAM;
						end
						mode_cyc = mode_cyc % HBLANK_LEN;
					end
				end
				MODE_VBLANK: begin
					vbl_cyc = vbl_cyc + VLC_W'(cyc);
					// at most one line per item, however many cycles came in
					if (vbl_cyc >= VBL_LINE_LEN) begin
						cur_line = cur_line + 1'b1;
						vbl_cyc = VLC_W'(vbl_cyc % VBL_LINE_LEN);
					end
					if (mode_cyc >= VBL_LEN) begin
						cur_line = '0;
						cur_mode = MODE_OAM;
						mode_cyc = mode_cyc % VBL_LEN;
						r.frame_done = 1'b1;
					end
				end
				MODE_OAM: begin
					if (mode_cyc >= OAM_LEN) begin
						cur_mode = MODE_XFER;
						mode_cyc = mode_cyc % OAM_LEN;
						r.sprite_search_event = 1'b1;
					end
				end
				default: begin
					if (mode_cyc >= XFER_LEN) begin
						cur_mode = MODE_HBLANK;
						mode_cyc = mode_cyc % XFER_LEN;
						r.line_render_event = 1'b1;
					end
				end
			endcase
		end
		r.mode = cur_mode;
		r.line = cur_line;
		return r;
	endfunction

	function automatic logic [7:0] pick_cycles();
		int unsigned roll;
		roll = $urandom_range(0, 9);
		if (roll < 3)
			return 8'($urandom_range(0, 31));
		else if (roll < 7)
			return 8'($urandom_range(0, 255));
		else if (roll < 9)
			return 8'd255;
		return 8'd0;
	endfunction

	task automatic queue_cycles(input logic [7:0] value, input logic calm);
		stim_t s;
		s.is_lcd = 1'b0;
		s.calm   = calm;
		s.value  = value;
		stim_q.push_back(s);
	endtask

	task automatic queue_lcd(input logic value);
		stim_t s;
		s.is_lcd = 1'b1;
		s.calm   = 1'b0;
		s.value  = {7'b0, value};
		stim_q.push_back(s);
	endtask

	task automatic queue_random(input int count, input logic calm);
		for (int i = 0; i < count; i++)
			queue_cycles(pick_cycles(), calm);
	endtask

	task automatic check_field(input string what, input int unsigned exp_v,
			input int unsigned act_v);
		if (exp_v != act_v) begin
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, exp_v,
				act_v);
			err_count++;
		end
	endtask

	// driver: cycle items and lcd_enable writes, prediction on accept
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid  <= 1'b0;
			s_tdata   <= '0;
			cfg_valid <= 1'b0;
			cfg_data  <= 1'b0;
			send_gap  = 0;
			drain_cnt = 0;
			cur_mode  = MODE_OAM;
			mode_cyc  = '0;
			vbl_cyc   = '0;
			cur_line  = '0;
			lcd_on    = 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				timing_q.push_back(advance_timing(s_tdata));
			if (cfg_valid && cfg_ready)
				lcd_on = cfg_data;

			if ((s_tvalid && !s_tready) || (cfg_valid && !cfg_ready)) begin
				// item still on offer
			end else if (send_gap != 0) begin
				send_gap--;
				s_tvalid  <= 1'b0;
				cfg_valid <= 1'b0;
			end else if (stim_q.size() == 0) begin
				s_tvalid  <= 1'b0;
				cfg_valid <= 1'b0;
			end else if (stim_q[0].is_lcd) begin
				// write only once every expected result is out and the pipe settled
				s_tvalid <= 1'b0;
				drain_cnt = (timing_q.size() == 0) ? drain_cnt + 1 : 0;
				if (drain_cnt > SETTLE_CYCLES) begin
					head = stim_q.pop_front();
					cfg_valid <= 1'b1;
					cfg_data  <= head.value[0];
					drain_cnt = 0;
				end else begin
					cfg_valid <= 1'b0;
				end
			end else begin
				head = stim_q.pop_front();
				cfg_valid  <= 1'b0;
				s_tvalid   <= 1'b1;
				s_tdata    <= head.value;
				calm_phase <= head.calm;
				if (!head.calm && $urandom_range(0, 5) == 0)
					send_gap = $urandom_range(1, 11);
			end
		end
	end

	// monitor: backpressure and result checks
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			sink_gap = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (timing_q.size() == 0) begin
					$display("%0t ns: unexpected result, expected none, got data %h last %b",
						$time, m_tdata, m_tlast);
					err_count++;
				end else begin
					want = timing_q.pop_front();
					check_field("mode", want.mode, m_tdata[1:0]);
					check_field("line", want.line, m_tdata[9:2]);
					check_field("vblank_irq", want.vblank_irq, m_tdata[10]);
					check_field("sprite_search_event", want.sprite_search_event, m_tdata[11]);
					check_field("line_render_event", want.line_render_event, m_tdata[12]);
					check_field("frame_done", want.frame_done, m_tlast);
					check_field("tdata padding", 0, m_tdata[15:13]);
				end
			end
			if (sink_gap != 0) begin
				sink_gap--;
				m_tready <= 1'b0;
			end else if (!calm_phase && $urandom_range(0, 9) == 0) begin
				sink_gap = $urandom_range(0, 10);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		// LCD off after reset: timing frozen
		queue_cycles(8'd255, 1'b0);
		queue_cycles(8'd0, 1'b0);
		queue_cycles(8'd37, 1'b0);
		queue_lcd(1'b1);
		// exact mode boundaries, then big steps that carry over by modulo
		queue_cycles(8'd0, 1'b0);
		queue_cycles(8'd19, 1'b0);
		queue_cycles(8'd1, 1'b0);
		queue_cycles(8'd42, 1'b0);
		queue_cycles(8'd1, 1'b0);
		queue_cycles(8'd50, 1'b0);
		queue_cycles(8'd1, 1'b0);
		queue_cycles(8'd255, 1'b0);
		queue_cycles(8'd255, 1'b0);
		queue_cycles(8'd255, 1'b0);
		for (int b = 7; b >= 0; b--)
			queue_cycles(8'(1 << b), 1'b0);
		queue_random(170, 1'b0);
		// switch off mid-frame, then resume
		queue_lcd(1'b0);
		queue_random(15, 1'b0);
		queue_lcd(1'b1);
		queue_random(170, 1'b0);
		queue_lcd(1'b1);
		queue_random(170, 1'b1);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(negedge clk);
		while (stim_q.size() != 0 || s_tvalid || cfg_valid || timing_q.size() != 0);
		repeat (8) @(posedge clk);

		if (err_count == 0 && timing_q.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
